[hw/rtl/mpr_pkg.sv]
`default_nettype none

package mpr_pkg;

    // Field widths
    localparam int NUM_W   = 64;
    localparam int DEPTH_W = 4;

    // Decimal form of one 64-bit value: 20 BCD digits
    localparam int BCD_DIGITS = 20;
    localparam int BCD_W      = BCD_DIGITS * 4;

    // Binary to BCD conversion: bits shifted in per cycle, conversion steps per number
    localparam int CONV_BITS  = 4;
    localparam int CONV_STEPS = NUM_W / CONV_BITS;
    localparam int CONV_CNT_W = $clog2(CONV_STEPS);

    localparam logic [NUM_W-1:0]   RADIX     = NUM_W'(10);
    localparam logic [DEPTH_W-1:0] DEPTH_MAX = DEPTH_W'(15);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_CONV,
        ST_MULT,
        ST_UPDATE
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic load;        // capture a new candidate
        logic conv_start;  // begin a round: load the BCD converter
        logic conv_step;   // shift CONV_BITS bits into the BCD register
        logic mult_step;   // fold one digit into the product
        logic commit;      // update the record and write the result register
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic rounds_done; // one digit left, or depth saturated
        logic conv_last;   // this conversion step is the final one
        logic mult_last;   // this digit is the final one of the round
    } t_dp_sts;

endpackage

`default_nettype wire

[hw/rtl/multiplicative_persistence_record_top.sv]
`default_nettype none

// Channel   Direction  Handshake          Payload
// request   in         i_valid / o_stall  i_candidate_number[63:0]
// result    out        o_valid / i_stall  o_persistence_depth[3:0], o_record_updated,
//                                         o_best_number[63:0], o_best_depth[3:0]
//
// Each request runs rounds until one digit remains or the depth saturates. A round
// converts the value to BCD, 4 bits a cycle, then folds its digits (at most 20, fewer
// on a zero digit) into the product with the single 64x4 multiplier, one digit per
// cycle.
// Reset (i_rst_n low, synchronous) sets the record to number 1 at depth 0.
// A result held by i_stall holds the block in its update state; a new request is
// taken as soon as the result register has been written.

module multiplicative_persistence_record_top (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    // request channel
    input  wire logic                        i_valid,
    output logic                             o_stall,
    input  wire logic [mpr_pkg::NUM_W-1:0]   i_candidate_number,
    // result channel
    output logic                             o_valid,
    input  wire logic                        i_stall,
    output logic      [mpr_pkg::DEPTH_W-1:0] o_persistence_depth,
    output logic                             o_record_updated,
    output logic      [mpr_pkg::NUM_W-1:0]   o_best_number,
    output logic      [mpr_pkg::DEPTH_W-1:0] o_best_depth
);

    // Command and status between the sequencer and the datapath
    mpr_pkg::t_dp_cmd w_cmd;
    mpr_pkg::t_dp_sts w_sts;

    // Sequencer: accept, run rounds until one digit remains or the depth saturates, then commit
    mpr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_cmd   (w_cmd),
        .i_sts   (w_sts)
    );

    // Datapath: BCD conversion, digit product, depth count, record and result registers
    mpr_datapath u_datapath (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (w_cmd),
        .o_sts               (w_sts),
        .i_candidate_number  (i_candidate_number),
        .o_persistence_depth (o_persistence_depth),
        .o_record_updated    (o_record_updated),
        .o_best_number       (o_best_number),
        .o_best_depth        (o_best_depth)
    );

endmodule

`default_nettype wire

[hw/rtl/mpr_datapath.sv]
`default_nettype none

module mpr_datapath (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire mpr_pkg::t_dp_cmd              i_cmd,
    output mpr_pkg::t_dp_sts                   o_sts,
    input  wire logic [mpr_pkg::NUM_W-1:0]     i_candidate_number,
    output logic      [mpr_pkg::DEPTH_W-1:0]   o_persistence_depth,
    output logic                               o_record_updated,
    output logic      [mpr_pkg::NUM_W-1:0]     o_best_number,
    output logic      [mpr_pkg::DEPTH_W-1:0]   o_best_depth
);

    logic [mpr_pkg::NUM_W-1:0]      r_cand;
    logic [mpr_pkg::NUM_W-1:0]      r_value;
    logic [mpr_pkg::DEPTH_W-1:0]    r_depth;
    logic [mpr_pkg::NUM_W-1:0]      r_shift;
    logic [mpr_pkg::BCD_W-1:0]      r_bcd;
    logic [mpr_pkg::CONV_CNT_W-1:0] r_conv_cnt;
    logic [mpr_pkg::NUM_W-1:0]      r_prod;
    logic [mpr_pkg::NUM_W-1:0]      r_best_number;
    logic [mpr_pkg::DEPTH_W-1:0]    r_best_depth;

    logic [mpr_pkg::NUM_W-1:0]      n_shift;
    logic [mpr_pkg::BCD_W-1:0]      n_bcd_conv;
    logic [mpr_pkg::NUM_W-1:0]      n_prod;
    logic                           w_deeper;
    logic                           w_update;

    // Double dabble: CONV_BITS bits per cycle, adjust every digit before each shift
    always_comb begin
        n_bcd_conv = r_bcd;
        n_shift    = r_shift;
        for (int s = 0; s < mpr_pkg::CONV_BITS; s++) begin
            for (int d = 0; d < mpr_pkg::BCD_DIGITS; d++) begin
                if (n_bcd_conv[d*4 +: 4] >= 4'd5) begin
                    n_bcd_conv[d*4 +: 4] = n_bcd_conv[d*4 +: 4] + 4'd3;
                end
            end
            n_bcd_conv = {n_bcd_conv[mpr_pkg::BCD_W-2:0], n_shift[mpr_pkg::NUM_W-1]};
            n_shift    = {n_shift[mpr_pkg::NUM_W-2:0], 1'b0};
        end
    end

    // One digit into the product per cycle, lowest digit first
    assign n_prod = r_prod * mpr_pkg::NUM_W'(r_bcd[3:0]);

    always_comb begin
        o_sts.rounds_done = (r_value < mpr_pkg::RADIX) || (r_depth == mpr_pkg::DEPTH_MAX);
        o_sts.conv_last   = (r_conv_cnt == mpr_pkg::CONV_CNT_W'(mpr_pkg::CONV_STEPS - 1));
        // a zero digit clears the product, so stop there too
        o_sts.mult_last   = (r_bcd[mpr_pkg::BCD_W-1:4] == '0) || (r_bcd[3:0] == 4'd0);
    end

    assign w_deeper = (r_depth > r_best_depth);
    assign w_update = w_deeper || ((r_depth == r_best_depth) && (r_cand < r_best_number));

    // Record: reset to number one at depth zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best_number <= mpr_pkg::NUM_W'(1);
            r_best_depth  <= '0;
        end else if (i_cmd.commit && w_update) begin
            r_best_number <= r_cand;
            if (w_deeper) begin
                r_best_depth <= r_depth;
            end
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cand  <= i_candidate_number;
            r_value <= i_candidate_number;
            r_depth <= '0;
        end
        if (i_cmd.conv_start) begin
            r_shift    <= r_value;
            r_bcd      <= '0;
            r_conv_cnt <= '0;
            r_prod     <= mpr_pkg::NUM_W'(1);
        end
        if (i_cmd.conv_step) begin
            r_shift    <= n_shift;
            r_bcd      <= n_bcd_conv;
            r_conv_cnt <= r_conv_cnt + mpr_pkg::CONV_CNT_W'(1);
        end
        if (i_cmd.mult_step) begin
            r_prod <= n_prod;
            r_bcd  <= {4'd0, r_bcd[mpr_pkg::BCD_W-1:4]};
            if (o_sts.mult_last) begin
                r_value <= n_prod;
                r_depth <= r_depth + mpr_pkg::DEPTH_W'(1);
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            o_persistence_depth <= r_depth;
            o_record_updated    <= w_update;
            o_best_number       <= w_update ? r_cand : r_best_number;
            o_best_depth        <= w_deeper ? r_depth : r_best_depth;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/mpr_ctrl.sv]
`default_nettype none

module mpr_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_stall,
    output logic                  o_valid,
    input  wire logic             i_stall,
    output mpr_pkg::t_dp_cmd      o_cmd,
    input  wire mpr_pkg::t_dp_sts i_sts
);

    mpr_pkg::t_state r_state;
    mpr_pkg::t_state n_state;
    logic            r_out_valid;
    logic            n_out_valid;
    logic            w_out_busy;

    assign w_out_busy = r_out_valid && i_stall;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            mpr_pkg::ST_IDLE: begin
                if (i_valid) begin
                    n_state = mpr_pkg::ST_CHECK;
                end
            end
            mpr_pkg::ST_CHECK: begin
                n_state = i_sts.rounds_done ? mpr_pkg::ST_UPDATE : mpr_pkg::ST_CONV;
            end
            mpr_pkg::ST_CONV: begin
                if (i_sts.conv_last) begin
                    n_state = mpr_pkg::ST_MULT;
                end
            end
            mpr_pkg::ST_MULT: begin
                if (i_sts.mult_last) begin
                    n_state = mpr_pkg::ST_CHECK;
                end
            end
            mpr_pkg::ST_UPDATE: begin
                if (!w_out_busy) begin
                    n_state = mpr_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = mpr_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb begin
        o_cmd   = '0;
        o_stall = 1'b1;
        case (r_state)
            mpr_pkg::ST_IDLE: begin
                o_stall    = 1'b0;
                o_cmd.load = i_valid;
            end
            mpr_pkg::ST_CHECK: begin
                o_cmd.conv_start = !i_sts.rounds_done;
            end
            mpr_pkg::ST_CONV: begin
                o_cmd.conv_step = 1'b1;
            end
            mpr_pkg::ST_MULT: begin
                o_cmd.mult_step = 1'b1;
            end
            mpr_pkg::ST_UPDATE: begin
                o_cmd.commit = !w_out_busy;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    assign n_out_valid = o_cmd.commit || w_out_busy;
    assign o_valid     = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mpr_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

`default_nettype wire
